// File: design/udm_pkg.sv
// Shared types, register codes and fixed-point helpers for the undistortion remap.
package udm_pkg;

   // Field widths fixed by the interface.
   localparam int PIX_W   = 10;
   localparam int COORD_W = 16;
   localparam int REG_W   = 32;
   localparam int CSR_IW  = 3;

   typedef logic signed [31:0] q28_type;
   typedef logic signed [63:0] prod_type;
   typedef logic signed [39:0] wide_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IW-1:0] {
      CSR_K1       = 3'd0,
      CSR_K2       = 3'd1,
      CSR_P1       = 3'd2,
      CSR_P2       = 3'd3,
      CSR_FOCAL_X  = 3'd4,
      CSR_FOCAL_Y  = 3'd5,
      CSR_CENTER_X = 3'd6,
      CSR_CENTER_Y = 3'd7
   } csr_index_type;

   // Reset values of the registers.
   localparam logic [31:0] K1_RESET       = 32'hFB77290F;
   localparam logic [31:0] K2_RESET       = 32'd19853237;
   localparam logic [31:0] P1_RESET       = 32'd51966;
   localparam logic [31:0] P2_RESET       = 32'd4730;
   localparam logic [31:0] FOCAL_X_RESET  = 32'd30058349;
   localparam logic [31:0] FOCAL_Y_RESET  = 32'd29969351;
   localparam logic [31:0] CENTER_X_RESET = 32'd24065802;
   localparam logic [31:0] CENTER_Y_RESET = 32'd16277504;

   localparam q28_type  Q28_ONE  = 32'sh1000_0000;
   localparam q28_type  Q28_MAX  = 32'sh7FFF_FFFF;
   localparam q28_type  Q28_MIN  = 32'sh8000_0000;
   localparam wide_type WIDE_MAX = 40'sh00_7FFF_FFFF;
   localparam wide_type WIDE_MIN = 40'shFF_8000_0000;

   // Sign extension of a Q4.28 value to the wide sum width.
   function automatic wide_type ext40(input q28_type a);
      return {{8{a[31]}}, a};
   endfunction

   // Clamp a wide sum to the Q4.28 range.
   function automatic q28_type sat_wide(input wide_type v);
      q28_type r;
      if (v > WIDE_MAX) begin
         r = Q28_MAX;
      end else if (v < WIDE_MIN) begin
         r = Q28_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Product rescaled by flooring shift of 28 bits, then clamped.
   function automatic q28_type qsat(input prod_type p);
      wide_type s;
      s = {{4{p[63]}}, p[63:28]};
      return sat_wide(s);
   endfunction

endpackage

// File: design/udm_if.sv
// Valid/ready channel interfaces for pixel requests and source coordinate responses.
interface udm_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] out_col;
   logic [9:0] out_row;
   modport source (output valid, output out_col, output out_row, input ready);
   modport sink (input valid, input out_col, input out_row, output ready);
endinterface

interface udm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] src_col;
   logic signed [15:0] src_row;
   logic               in_frame;
   modport source (output valid, output src_col, output src_row, output in_frame,
                   input ready);
   modport sink (input valid, input src_col, input src_row, input in_frame,
                 output ready);
endinterface

// File: design/lens_undistort_coordinate_map.sv
// Each accepted request word yields one response word, in order.
// Throughput: one word per cycle unless held; the two axis dividers, 32 quotient stages each, set most of the depth.
// The whole pipeline advances together and holds in place while the response
// register is full and not taken. Synchronous active-high reset clears all valid
// bits and loads the register reset values; no clearing pass is needed.
module lens_undistort_coordinate_map
   import udm_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 1024,
   parameter int IMAGE_HEIGHT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   udm_req_if.sink           req_chan,
   udm_rsp_if.source         rsp_chan,
   input  logic              csr_write_enable,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [REG_W-1:0]  csr_write_data
);

   localparam logic [COORD_W-1:0] WIDTH_LIM  = COORD_W'(IMAGE_WIDTH);
   localparam logic [COORD_W-1:0] HEIGHT_LIM = COORD_W'(IMAGE_HEIGHT);
   localparam int                 LATENCY    = 46;

   // Configuration registers.
   logic [31:0] k1_ff, k2_ff, p1_ff, p2_ff;
   logic [31:0] fx_ff, fy_ff, cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff <= K1_RESET;
         k2_ff <= K2_RESET;
         p1_ff <= P1_RESET;
         p2_ff <= P2_RESET;
         fx_ff <= FOCAL_X_RESET;
         fy_ff <= FOCAL_Y_RESET;
         cx_ff <= CENTER_X_RESET;
         cy_ff <= CENTER_Y_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_K1:       k1_ff <= csr_write_data;
            CSR_K2:       k2_ff <= csr_write_data;
            CSR_P1:       p1_ff <= csr_write_data;
            CSR_P2:       p2_ff <= csr_write_data;
            CSR_FOCAL_X:  fx_ff <= csr_write_data;
            CSR_FOCAL_Y:  fy_ff <= csr_write_data;
            CSR_CENTER_X: cx_ff <= csr_write_data;
            CSR_CENTER_Y: cy_ff <= csr_write_data;
            default:      k1_ff <= k1_ff;
         endcase
      end
   end

   // Global pipeline enable: move unless the response word is stuck.
   logic rsp_valid_ff;
   logic advance;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   logic    req_fire;
   assign   req_fire = req_chan.valid && advance;

   // Normalization of both axes.
   logic    vx, vy;
   q28_type xn, yn;

   udm_divider u_div_x (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_fire),
      .pix       (req_chan.out_col),
      .center    (cx_ff),
      .focal     (fx_ff),
      .out_valid (vx),
      .quot      (xn)
   );

   udm_divider u_div_y (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_fire),
      .pix       (req_chan.out_row),
      .center    (cy_ff),
      .focal     (fy_ff),
      .out_valid (vy),
      .quot      (yn)
   );

   // Distortion polynomial.
   logic    vd;
   q28_type xd, yd;

   udm_distort u_distort (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (vx && vy),
      .x         (xn),
      .y         (yn),
      .k1        (q28_type'(k1_ff)),
      .k2        (q28_type'(k2_ff)),
      .p1        (q28_type'(p1_ff)),
      .p2        (q28_type'(p2_ff)),
      .out_valid (vd),
      .xd        (xd),
      .yd        (yd)
   );

   // Back to pixel coordinates.
   logic                      vpx, vpy;
   logic signed [COORD_W-1:0] sc, sr;

   udm_project u_proj_x (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (vd),
      .d         (xd),
      .focal     (fx_ff),
      .center    (cx_ff),
      .out_valid (vpx),
      .coord     (sc)
   );

   udm_project u_proj_y (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (vd),
      .d         (yd),
      .focal     (fy_ff),
      .center    (cy_ff),
      .out_valid (vpy),
      .coord     (sr)
   );

   // Response register with the frame bounds check.
   logic                      in_frame_in, in_frame_ff;
   logic signed [COORD_W-1:0] src_col_ff, src_row_ff;

   assign in_frame_in = !sc[COORD_W-1] && !sr[COORD_W-1]
                        && (sc < WIDTH_LIM) && (sr < HEIGHT_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vpx && vpy;
      end
      if (advance) begin
         src_col_ff  <= sc;
         src_row_ff  <= sr;
         in_frame_ff <= in_frame_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.src_col  = src_col_ff;
   assign rsp_chan.src_row  = src_row_ff;
   assign rsp_chan.in_frame = in_frame_ff;

   // Words in flight, for checking.
   logic [5:0] inflight_ff;
   logic [5:0] inflight_in;
   logic       rsp_fire;

   assign rsp_fire    = rsp_valid_ff && rsp_chan.ready;
   assign inflight_in = inflight_ff + 6'(req_fire) - 6'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 6'(LATENCY))
      else $error("more words in flight than pipeline stages");

   a_empty_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (inflight_ff == 6'd0) |-> !rsp_chan.valid)
      else $error("response word without a matching request");

   a_frame_nonneg: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.in_frame) |->
         (!rsp_chan.src_col[COORD_W-1] && !rsp_chan.src_row[COORD_W-1]))
      else $error("in-frame flag set on a negative coordinate");
`endif

endmodule

// File: design/udm_divider.sv
// Pipelined restoring divider that normalizes one pixel axis to Q4.28.
module udm_divider
   import udm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [PIX_W-1:0] pix,
   input  logic [31:0]      center,
   input  logic [31:0]      focal,
   output logic             out_valid,
   output q28_type          quot
);

   localparam int STEPS = 32;

   // Signed pixel offset from the principal point and its magnitude.
   logic signed [33:0] diff;
   logic        [33:0] mag_full;
   logic        [31:0] absd;
   logic               ovf_pre;

   assign diff     = $signed({8'b0, pix, 16'b0}) - $signed({2'b0, center});
   assign mag_full = diff[33] ? 34'(-diff) : diff;
   assign absd     = mag_full[31:0];
   assign ovf_pre  = {4'b0, absd} >= {focal, 4'b0};

   logic              valid_ff [0:STEPS];
   logic [31:0]       rem_ff   [0:STEPS];
   logic [31:0]       q_ff     [0:STEPS];
   logic [3:0]        lo_ff    [0:STEPS];
   logic              neg_ff   [0:STEPS];
   logic              ovf_ff   [0:STEPS];
   logic              zero_ff  [0:STEPS];

   // Entry stage: seed the partial remainder with the high dividend bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
      if (advance) begin
         rem_ff[0]  <= {4'b0, absd[31:4]};
         q_ff[0]    <= '0;
         lo_ff[0]   <= absd[3:0];
         neg_ff[0]  <= diff[33];
         ovf_ff[0]  <= ovf_pre;
         zero_ff[0] <= (focal == 32'd0);
      end
   end

   // One quotient bit per stage.
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [32:0] trial;
      logic [32:0] trial_sub;
      logic        ge;

      assign trial     = {rem_ff[i], lo_ff[i][3]};
      assign ge        = trial >= {1'b0, focal};
      assign trial_sub = trial - {1'b0, focal};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (advance) begin
            rem_ff[i+1]  <= ge ? trial_sub[31:0] : trial[31:0];
            q_ff[i+1]    <= {q_ff[i][30:0], ge};
            lo_ff[i+1]   <= {lo_ff[i][2:0], 1'b0};
            neg_ff[i+1]  <= neg_ff[i];
            ovf_ff[i+1]  <= ovf_ff[i];
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   // Apply the sign and clamp to the Q4.28 range; a zero focal length gives zero.
   q28_type quot_in;
   q28_type quot_ff;
   logic    out_valid_ff;

   always_comb begin
      if (zero_ff[STEPS]) begin
         quot_in = '0;
      end else if (ovf_ff[STEPS]) begin
         quot_in = neg_ff[STEPS] ? Q28_MIN : Q28_MAX;
      end else if (neg_ff[STEPS]) begin
         quot_in = (q_ff[STEPS] > 32'h8000_0000) ? Q28_MIN : q28_type'(-q_ff[STEPS]);
      end else begin
         quot_in = q_ff[STEPS][31] ? Q28_MAX : q28_type'(q_ff[STEPS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[STEPS];
      end
      if (advance) begin
         quot_ff <= quot_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign quot      = quot_ff;

endmodule

// File: design/udm_distort.sv
// Radial and tangential distortion polynomial, one multiply level per stage pair.
module udm_distort
   import udm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  q28_type x,
   input  q28_type y,
   input  q28_type k1,
   input  q28_type k2,
   input  q28_type p1,
   input  q28_type p2,
   output logic    out_valid,
   output q28_type xd,
   output q28_type yd
);

   logic [7:0] valid_ff;
   logic [7:0] valid_in;

   assign valid_in = {valid_ff[6:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Stage a: squares and cross product.
   prod_type pxx_ff, pyy_ff, pxy_ff;
   q28_type  x_a_ff, y_a_ff;
   // Stage b: rescaled squares and r squared.
   q28_type  x2_b_ff, y2_b_ff, xy_b_ff, r2_b_ff, x_b_ff, y_b_ff;
   // Stage c: r to the fourth and k1 term products, tangential sums.
   prod_type prr_c_ff, pk1_c_ff;
   q28_type  tx_c_ff, ty_c_ff, xy_c_ff, x_c_ff, y_c_ff;
   // Stage d: rescaled r4 and k1 term.
   q28_type  r4_d_ff, kr_d_ff, tx_d_ff, ty_d_ff, xy_d_ff, x_d_ff, y_d_ff;
   // Stage e: k2 term product.
   prod_type pk2_e_ff;
   q28_type  kr_e_ff, tx_e_ff, ty_e_ff, xy_e_ff, x_e_ff, y_e_ff;
   // Stage f: radial gain.
   q28_type  rad_f_ff, tx_f_ff, ty_f_ff, xy_f_ff, x_f_ff, y_f_ff;
   // Stage g: final products.
   prod_type pxr_g_ff, pyr_g_ff, pp1xy_g_ff, pp2tx_g_ff, pp2xy_g_ff, pp1ty_g_ff;
   // Stage h: distorted coordinates.
   q28_type  xd_h_ff, yd_h_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         pxx_ff <= x * x;
         pyy_ff <= y * y;
         pxy_ff <= x * y;
         x_a_ff <= x;
         y_a_ff <= y;

         x2_b_ff <= qsat(pxx_ff);
         y2_b_ff <= qsat(pyy_ff);
         xy_b_ff <= qsat(pxy_ff);
         r2_b_ff <= sat_wide(ext40(qsat(pxx_ff)) + ext40(qsat(pyy_ff)));
         x_b_ff  <= x_a_ff;
         y_b_ff  <= y_a_ff;

         prr_c_ff <= r2_b_ff * r2_b_ff;
         pk1_c_ff <= k1 * r2_b_ff;
         tx_c_ff  <= sat_wide(ext40(r2_b_ff) + (ext40(x2_b_ff) <<< 1));
         ty_c_ff  <= sat_wide(ext40(r2_b_ff) + (ext40(y2_b_ff) <<< 1));
         xy_c_ff  <= xy_b_ff;
         x_c_ff   <= x_b_ff;
         y_c_ff   <= y_b_ff;

         r4_d_ff <= qsat(prr_c_ff);
         kr_d_ff <= qsat(pk1_c_ff);
         tx_d_ff <= tx_c_ff;
         ty_d_ff <= ty_c_ff;
         xy_d_ff <= xy_c_ff;
         x_d_ff  <= x_c_ff;
         y_d_ff  <= y_c_ff;

         pk2_e_ff <= k2 * r4_d_ff;
         kr_e_ff  <= kr_d_ff;
         tx_e_ff  <= tx_d_ff;
         ty_e_ff  <= ty_d_ff;
         xy_e_ff  <= xy_d_ff;
         x_e_ff   <= x_d_ff;
         y_e_ff   <= y_d_ff;

         rad_f_ff <= sat_wide(ext40(Q28_ONE) + ext40(kr_e_ff) + ext40(qsat(pk2_e_ff)));
         tx_f_ff  <= tx_e_ff;
         ty_f_ff  <= ty_e_ff;
         xy_f_ff  <= xy_e_ff;
         x_f_ff   <= x_e_ff;
         y_f_ff   <= y_e_ff;

         pxr_g_ff   <= x_f_ff * rad_f_ff;
         pyr_g_ff   <= y_f_ff * rad_f_ff;
         pp1xy_g_ff <= p1 * xy_f_ff;
         pp2tx_g_ff <= p2 * tx_f_ff;
         pp2xy_g_ff <= p2 * xy_f_ff;
         pp1ty_g_ff <= p1 * ty_f_ff;

         xd_h_ff <= sat_wide(ext40(qsat(pxr_g_ff)) + (ext40(qsat(pp1xy_g_ff)) <<< 1)
                             + ext40(qsat(pp2tx_g_ff)));
         yd_h_ff <= sat_wide(ext40(qsat(pyr_g_ff)) + (ext40(qsat(pp2xy_g_ff)) <<< 1)
                             + ext40(qsat(pp1ty_g_ff)));
      end
   end

   assign out_valid = valid_ff[7];
   assign xd        = xd_h_ff;
   assign yd        = yd_h_ff;

endmodule

// File: design/udm_project.sv
// Maps one distorted normalized axis back to a saturated whole pixel.
module udm_project
   import udm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  q28_type                   d,
   input  logic [31:0]               focal,
   input  logic [31:0]               center,
   output logic                      out_valid,
   output logic signed [COORD_W-1:0] coord
);

   logic [2:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   logic signed [64:0]        prod_in, prod_ff;
   wide_type                  q16_in, q16_ff;
   logic signed [23:0]        whole;
   logic signed [COORD_W-1:0] coord_in, coord_ff;

   // Scale by the focal length, then add the principal point in Q16.16.
   assign prod_in = d * $signed({1'b0, focal});
   assign q16_in  = {{3{prod_ff[64]}}, prod_ff[64:28]} + $signed({8'b0, center});

   // Truncate toward zero and clamp to 16 bits.
   always_comb begin
      whole = q16_ff[39:16];
      if (q16_ff[39] && (q16_ff[15:0] != 16'd0)) begin
         whole = whole + 24'sd1;
      end
      if (whole > 24'sd32767) begin
         coord_in = 16'sh7FFF;
      end else if (whole < -24'sd32768) begin
         coord_in = 16'sh8000;
      end else begin
         coord_in = whole[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         q16_ff   <= q16_in;
         coord_ff <= coord_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign coord     = coord_ff;

endmodule

// File: tb/sv/lens_undistort_coordinate_map_tb.sv
// Testbench for the undistortion coordinate map: directed and random pixels vs a predictor.
module lens_undistort_coordinate_map_tb;
   import udm_pkg::*;

   localparam int IMG_W       = 1024;
   localparam int IMG_H       = 1024;
   localparam int LATENCY     = 46;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [15:0] src_col;
      logic signed [15:0] src_row;
      logic               in_frame;
   } src_coord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [REG_W-1:0] csr_write_data = '0;

   udm_req_if req_chan ();
   udm_rsp_if rsp_chan ();

   lens_undistort_coordinate_map DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #1 clock = ~clock;

   // Predictor copy of the lens registers.
   logic [31:0] lens_reg [8];
   src_coord_type expected_coords [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit idle_enabled = 1'b1;

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint floor28(input longint p);
      return p >>> 28;
   endfunction

   function automatic longint fixmul(input longint a, input longint b);
      return clamp32(floor28(a * b));
   endfunction

   function automatic longint to_norm(input logic [9:0] pix, input logic [31:0] ctr,
                                      input logic [31:0] foc);
      longint diff;
      diff = (longint'(pix) <<< 16) - longint'(ctr);
      if (foc == 0) return 0;
      // Signed 64-bit division truncates toward zero.
      return clamp32((diff * 64'sd268435456) / longint'(foc));
   endfunction

   function automatic longint to_pix(input longint d, input logic [31:0] foc,
                                     input logic [31:0] ctr);
      longint q16, whole;
      q16 = floor28(d * longint'(foc)) + longint'(ctr);
      whole = q16 / 65536;
      if (whole > 32767) whole = 32767;
      if (whole < -32768) whole = -32768;
      return whole;
   endfunction

   function automatic src_coord_type map_pixel(input logic [9:0] col, input logic [9:0] row);
      longint k1, k2, p1, p2, x, y, x2, y2, xy, r2, r4, rad, xd, yd, sc, sr;
      src_coord_type res;
      k1 = longint'($signed(lens_reg[CSR_K1]));
      k2 = longint'($signed(lens_reg[CSR_K2]));
      p1 = longint'($signed(lens_reg[CSR_P1]));
      p2 = longint'($signed(lens_reg[CSR_P2]));
      x = to_norm(col, lens_reg[CSR_CENTER_X], lens_reg[CSR_FOCAL_X]);
      y = to_norm(row, lens_reg[CSR_CENTER_Y], lens_reg[CSR_FOCAL_Y]);
      x2 = fixmul(x, x);
      y2 = fixmul(y, y);
      xy = fixmul(x, y);
      r2 = clamp32(x2 + y2);
      r4 = fixmul(r2, r2);
      rad = clamp32(64'sd268435456 + fixmul(k1, r2) + fixmul(k2, r4));
      xd = clamp32(fixmul(x, rad) + 2 * fixmul(p1, xy) + fixmul(p2, clamp32(r2 + 2 * x2)));
      yd = clamp32(fixmul(y, rad) + 2 * fixmul(p2, xy) + fixmul(p1, clamp32(r2 + 2 * y2)));
      sc = to_pix(xd, lens_reg[CSR_FOCAL_X], lens_reg[CSR_CENTER_X]);
      sr = to_pix(yd, lens_reg[CSR_FOCAL_Y], lens_reg[CSR_CENTER_Y]);
      res.src_col = sc[15:0];
      res.src_row = sr[15:0];
      res.in_frame = (sc >= 0 && sr >= 0 && sc < IMG_W && sr < IMG_H);
      return res;
   endfunction

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response side: random stalls and comparison against the oldest expected word.
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (idle_enabled && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(1, 8);
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_coords.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response word col=%0d row=%0d",
                           rsp_chan.src_col, rsp_chan.src_row);
            end else begin
               src_coord_type exp_c;
               exp_c = expected_coords.pop_front();
               if (exp_c.src_col !== rsp_chan.src_col || exp_c.src_row !== rsp_chan.src_row
                   || exp_c.in_frame !== rsp_chan.in_frame) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                              exp_c.src_col, exp_c.src_row, exp_c.in_frame,
                              rsp_chan.src_col, rsp_chan.src_row, rsp_chan.in_frame);
               end
            end
         end
      end
   end

   // Send one pixel word, idling first at random, and record its prediction.
   task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
      int gap;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.out_col <= col;
      req_chan.out_row <= row;
      expected_coords.push_back(map_pixel(col, row));
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic end_burst();
      req_chan.valid <= 1'b0;
   endtask

   // Wait until every word has returned, then let the pipeline drain.
   task automatic drain();
      end_burst();
      @(posedge clock);
      while (expected_coords.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // One register write, after which the write port is left quiet.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      lens_reg[idx] = val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_pixels(input int n);
      repeat (n) send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   task automatic test_reset_lens();
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd367, 10'd248);
      send_pixel(10'h2AA, 10'h155);
      send_pixel(10'h155, 10'h2AA);
      random_pixels(300);
      drain();
   endtask

   // Zero focal lengths collapse each axis onto the principal point.
   task automatic test_zero_focal();
      write_reg(CSR_FOCAL_X, 32'd0);
      write_reg(CSR_FOCAL_Y, 32'd0);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd512);
      drain();
   endtask

   // Extreme coefficients, a small horizontal and a maximal vertical focal length drive saturation.
   task automatic test_saturation();
      write_reg(CSR_K1, 32'h7FFF_FFFF);
      write_reg(CSR_K2, 32'h8000_0000);
      write_reg(CSR_P1, 32'h8000_0000);
      write_reg(CSR_P2, 32'h7FFF_FFFF);
      write_reg(CSR_FOCAL_X, 32'h0001_0000);
      write_reg(CSR_FOCAL_Y, 32'hFFFF_FFFF);
      write_reg(CSR_CENTER_X, 32'hFFFF_FFFF);
      write_reg(CSR_CENTER_Y, 32'd0);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd5, 10'd700);
      random_pixels(150);
      drain();
   endtask

   // Identity lens: small negative values truncate to zero and stay in frame.
   task automatic test_identity();
      write_reg(CSR_K1, 32'd0);
      write_reg(CSR_K2, 32'd0);
      write_reg(CSR_P1, 32'd0);
      write_reg(CSR_P2, 32'd0);
      write_reg(CSR_FOCAL_X, 32'd65536 * 700);
      write_reg(CSR_FOCAL_Y, 32'd65536 * 650);
      write_reg(CSR_CENTER_X, 32'd65536 * 512 + 32'd32768);
      write_reg(CSR_CENTER_Y, 32'd65536 * 300 + 32'd100);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd512, 10'd300);
      send_pixel(10'd511, 10'd299);
      random_pixels(150);
      drain();
   endtask

   // Random lens settings, one per phase.
   task automatic test_random_lenses();
      repeat (6) begin
         write_reg(CSR_K1, $urandom_range(0, 1) ? $urandom :
                   32'($signed($urandom_range(0, 2**26)) - 2**25));
         write_reg(CSR_K2, $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 2**24)));
         write_reg(CSR_P1, $urandom);
         write_reg(CSR_P2, $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 2**20)));
         write_reg(CSR_FOCAL_X, $urandom_range(0, 1) ? $urandom :
                   32'($urandom_range(65536, 65536 * 2000)));
         write_reg(CSR_FOCAL_Y, $urandom_range(0, 1) ? $urandom :
                   32'($urandom_range(65536, 65536 * 2000)));
         write_reg(CSR_CENTER_X, $urandom_range(0, 1) ? $urandom :
                   32'($urandom_range(0, 65536 * 1024)));
         write_reg(CSR_CENTER_Y, $urandom_range(0, 1) ? $urandom :
                   32'($urandom_range(0, 65536 * 1024)));
         random_pixels(150);
         drain();
      end
   endtask

   // Final stretch at full rate with no idling on either side.
   task automatic test_full_rate();
      idle_enabled = 1'b0;
      random_pixels(150);
      drain();
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.out_col = '0;
      req_chan.out_row = '0;
      lens_reg[CSR_K1] = K1_RESET;
      lens_reg[CSR_K2] = K2_RESET;
      lens_reg[CSR_P1] = P1_RESET;
      lens_reg[CSR_P2] = P2_RESET;
      lens_reg[CSR_FOCAL_X] = FOCAL_X_RESET;
      lens_reg[CSR_FOCAL_Y] = FOCAL_Y_RESET;
      lens_reg[CSR_CENTER_X] = CENTER_X_RESET;
      lens_reg[CSR_CENTER_Y] = CENTER_Y_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_lens();
      test_zero_focal();
      test_saturation();
      test_identity();
      test_random_lenses();
      test_full_rate();
      if (mismatch_count == 0 && expected_coords.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
